@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Whenever ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/lbe3d_pkg.sv @@
package lbe3d_pkg;

   // Default number of fraction bits of coordinates, scales and results.
   localparam int FRAC_BITS_DEF = 16;

   // Fixed field widths.
   localparam int COORD_W   = 18;
   localparam int OUT_W     = 32;
   localparam int SCALE_W   = 31;
   localparam int IDX_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CONST_W   = 34;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASIS_SET = 2'd0,
      CSR_X_SCALE   = 2'd1,
      CSR_Y_SCALE   = 2'd2,
      CSR_Z_SCALE   = 2'd3
   } csr_idx_type;

   // Basis set codes.
   localparam logic [1:0] BASIS_SET_20 = 2'd3;

   // Normalization constants with 30 fraction bits.
   localparam logic [CONST_W-1:0] K_ONE  = 34'd1073741824;
   localparam logic [CONST_W-1:0] K_R3   = 34'd1859775393;
   localparam logic [CONST_W-1:0] K_3    = 34'd3221225472;
   localparam logic [CONST_W-1:0] K_H5   = 34'd1200479854;
   localparam logic [CONST_W-1:0] K_3R5  = 34'd7202879124;
   localparam logic [CONST_W-1:0] K_H15  = 34'd2079292101;
   localparam logic [CONST_W-1:0] K_3R15 = 34'd12475752608;
   localparam logic [CONST_W-1:0] K_3R3  = 34'd5579326180;
   localparam logic [CONST_W-1:0] K_H7   = 34'd1420426919;
   localparam logic [CONST_W-1:0] K_D7   = 34'd4261280758;

   // Number of basis functions for a basis set code.
   function automatic logic [IDX_W-1:0] basis_count(input logic [1:0] set_code);
      logic [IDX_W-1:0] cnt;
      unique case (set_code)
         2'd0:    cnt = 5'd1;
         2'd1:    cnt = 5'd4;
         2'd2:    cnt = 5'd10;
         default: cnt = 5'd20;
      endcase
      return cnt;
   endfunction

endpackage

@@ hw/rtl/lbe3d_if.sv @@
// Point channel: one beat carries one reference point.
interface lbe3d_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [lbe3d_pkg::COORD_W-1:0]     xi_coord;
   logic signed [lbe3d_pkg::COORD_W-1:0]     eta_coord;
   logic signed [lbe3d_pkg::COORD_W-1:0]     zeta_coord;
   logic                                     final_point;

   modport source (output valid, xi_coord, eta_coord, zeta_coord, final_point,
                   input ready);
   modport sink   (input valid, xi_coord, eta_coord, zeta_coord, final_point,
                   output ready);
endinterface

// Result channel: one beat carries one basis function and its gradient.
interface lbe3d_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic        [lbe3d_pkg::IDX_W-1:0]       basis_index;
   logic signed [lbe3d_pkg::OUT_W-1:0]       basis_value;
   logic signed [lbe3d_pkg::OUT_W-1:0]       grad_x;
   logic signed [lbe3d_pkg::OUT_W-1:0]       grad_y;
   logic signed [lbe3d_pkg::OUT_W-1:0]       grad_z;
   logic                                     last_basis;
   logic                                     last_of_set;

   modport source (output valid, basis_index, basis_value, grad_x, grad_y, grad_z,
                   last_basis, last_of_set, input ready);
   modport sink   (input valid, basis_index, basis_value, grad_x, grad_y, grad_z,
                   last_basis, last_of_set, output ready);
endinterface

@@ hw/rtl/legendre_basis_eval_3d.sv @@
// Throughput: one result beat per cycle while rsp.ready does not stall the output.
// A point holds the sequencer for N result beats (N = 1, 4, 10 or 20 by basis_set);
// the next point is taken as the last basis index of the current one issues.
// The sequencer stage that walks the basis index sets this pace.
// Reset is synchronous and active high: it empties the pipeline, sets basis_set
// to 20 functions and all three gradient scales to 2.0.
`include "assert_macros.svh"

module legendre_basis_eval_3d #(
   parameter int FRAC_BITS = lbe3d_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lbe3d_req_if.sink                             req,
   lbe3d_rsp_if.source                           rsp,
   input  logic                                  csr_wr_en,
   input  logic [lbe3d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbe3d_pkg::SCALE_W-1:0]         csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int CRW = lbe3d_pkg::COORD_W;
   localparam int KW  = lbe3d_pkg::CONST_W;
   localparam int SW  = lbe3d_pkg::SCALE_W;
   localparam int OW  = lbe3d_pkg::OUT_W;
   localparam int XW  = lbe3d_pkg::IDX_W;
   // Polynomial width, large enough for every term at any fraction width.
   localparam int PW  = ((55 - 2 * F) > (F + 4)) ? (55 - 2 * F) : (F + 4);
   localparam int MW  = PW + CRW;            // point products
   localparam int KH  = KW / 2;              // constant split point
   localparam int P2W = PW + KH + 1;         // polynomial times constant half
   localparam int FW  = PW + KW + 1;         // polynomial times constant
   localparam int DW  = ((FW - 29) > (OW + 1)) ? (FW - 29) : (OW + 1);
   localparam int SH  = 16;                  // scale split point
   localparam int S2W = DW + SH + 1;         // term times scale half
   localparam int GW  = DW + SW + 2;         // term times scale

   localparam logic signed [PW-1:0] ONE_FX   = PW'(1) << F;
   localparam logic signed [PW-1:0] THREE_FX = (PW'(1) << (F + 1)) + (PW'(1) << F);
   localparam logic [SW-1:0]        SCALE_RST = SW'(2) << F;

   // Round half away from zero, for point products.
   function automatic logic signed [MW-1:0] rnd_pt(input logic signed [MW-1:0] v);
      logic [MW-1:0] mag;
      logic [MW-1:0] res;
      mag = v[MW-1] ? MW'(-v) : MW'(v);
      res = (mag + (MW'(1) << (F - 1))) >> F;
      return v[MW-1] ? -$signed(res) : $signed(res);
   endfunction

   // Round half away from zero by the 30 constant fraction bits.
   function automatic logic signed [FW-1:0] rnd_k(input logic signed [FW-1:0] v);
      logic [FW-1:0] mag;
      logic [FW-1:0] res;
      mag = v[FW-1] ? FW'(-v) : FW'(v);
      res = (mag + (FW'(1) << 29)) >> 30;
      return v[FW-1] ? -$signed(res) : $signed(res);
   endfunction

   // Round half away from zero, for scaled gradients.
   function automatic logic signed [GW-1:0] rnd_g(input logic signed [GW-1:0] v);
      logic [GW-1:0] mag;
      logic [GW-1:0] res;
      mag = v[GW-1] ? GW'(-v) : GW'(v);
      res = (mag + (GW'(1) << (F - 1))) >> F;
      return v[GW-1] ? -$signed(res) : $signed(res);
   endfunction

   function automatic logic [OW-1:0] sat_d(input logic signed [DW-1:0] v);
      logic fits;
      fits = (&v[DW-1:OW-1]) | ~(|v[DW-1:OW-1]);
      return fits ? v[OW-1:0] : (v[DW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});
   endfunction

   function automatic logic [OW-1:0] sat_g(input logic signed [GW-1:0] v);
      logic fits;
      fits = (&v[GW-1:OW-1]) | ~(|v[GW-1:OW-1]);
      return fits ? v[OW-1:0] : (v[GW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});
   endfunction

   // ---------------------------------------------------------------- registers
   logic [1:0]           set_ff, set_in;
   logic [SW-1:0]        scl_ff [3];
   logic [SW-1:0]        scl_in [3];

   logic                 a_vld_ff, a_vld_in, a_last_ff, a_last_in;
   logic signed [CRW-1:0] a_c_ff [3];
   logic signed [CRW-1:0] a_c_in [3];

   logic                 b_vld_ff, b_vld_in, b_last_ff, b_last_in;
   logic signed [CRW-1:0] b_c_ff [3];
   logic signed [CRW-1:0] b_c_in [3];
   logic signed [PW-1:0] b_sq_ff [3];
   logic signed [PW-1:0] b_sq_in [3];
   logic signed [PW-1:0] b_cr_ff [3];   // xy, xz, yz
   logic signed [PW-1:0] b_cr_in [3];

   logic                 c_vld_ff, c_vld_in, c_last_ff, c_last_in;
   logic signed [CRW-1:0] c_c_ff [3];
   logic signed [CRW-1:0] c_c_in [3];
   logic signed [PW-1:0] c_cr_ff [3];
   logic signed [PW-1:0] c_cr_in [3];
   logic signed [PW-1:0] c_xyz_ff, c_xyz_in;
   logic signed [PW-1:0] c_q_ff [3];    // 3u^2 - 1
   logic signed [PW-1:0] c_q_in [3];
   logic signed [PW-1:0] c_d5_ff [3];   // 5u^2 - 1
   logic signed [PW-1:0] c_d5_in [3];
   logic signed [PW-1:0] c_c5_ff [3];   // 5u^2 - 3
   logic signed [PW-1:0] c_c5_in [3];

   logic                 s_vld_ff, s_vld_in, s_last_ff, s_last_in;
   logic [XW-1:0]        k_ff, k_in;
   logic signed [CRW-1:0] s_c_ff [3];
   logic signed [CRW-1:0] s_c_in [3];
   logic signed [PW-1:0] s_cr_ff [3];
   logic signed [PW-1:0] s_cr_in [3];
   logic signed [PW-1:0] s_xyz_ff, s_xyz_in;
   logic signed [PW-1:0] s_q_ff [3];
   logic signed [PW-1:0] s_q_in [3];
   logic signed [PW-1:0] s_d5_ff [3];
   logic signed [PW-1:0] s_d5_in [3];
   logic signed [PW-1:0] s_lq_ff [6];   // yqx, zqx, xqy, zqy, xqz, yqz
   logic signed [PW-1:0] s_lq_in [6];
   logic signed [PW-1:0] s_cb_ff [3];   // u(5u^2 - 3)
   logic signed [PW-1:0] s_cb_in [3];

   logic                 r1_vld_ff, r1_vld_in, r1_lb_ff, r1_lb_in, r1_ls_ff, r1_ls_in;
   logic [XW-1:0]        r1_idx_ff, r1_idx_in;
   logic signed [PW-1:0] r1_p_ff [4];
   logic signed [PW-1:0] r1_p_in [4];
   logic [KW-1:0]        r1_k_ff [4];
   logic [KW-1:0]        r1_k_in [4];

   logic                 r2_vld_ff, r2_vld_in, r2_lb_ff, r2_lb_in, r2_ls_ff, r2_ls_in;
   logic [XW-1:0]        r2_idx_ff, r2_idx_in;
   logic signed [P2W-1:0] r2_pl_ff [4];
   logic signed [P2W-1:0] r2_pl_in [4];
   logic signed [P2W-1:0] r2_ph_ff [4];
   logic signed [P2W-1:0] r2_ph_in [4];

   logic                 r3_vld_ff, r3_vld_in, r3_lb_ff, r3_lb_in, r3_ls_ff, r3_ls_in;
   logic [XW-1:0]        r3_idx_ff, r3_idx_in;
   logic signed [DW-1:0] r3_d_ff [4];
   logic signed [DW-1:0] r3_d_in [4];

   logic                 r4_vld_ff, r4_vld_in, r4_lb_ff, r4_lb_in, r4_ls_ff, r4_ls_in;
   logic [XW-1:0]        r4_idx_ff, r4_idx_in;
   logic signed [DW-1:0] r4_v_ff, r4_v_in;
   logic signed [S2W-1:0] r4_gl_ff [3];
   logic signed [S2W-1:0] r4_gl_in [3];
   logic signed [S2W-1:0] r4_gh_ff [3];
   logic signed [S2W-1:0] r4_gh_in [3];

   logic                 rsp_vld_ff, rsp_vld_in, rsp_lb_ff, rsp_lb_in, rsp_ls_ff, rsp_ls_in;
   logic [XW-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [OW-1:0]        rsp_val_ff, rsp_val_in;
   logic [OW-1:0]        rsp_g_ff [3];
   logic [OW-1:0]        rsp_g_in [3];

   // ---------------------------------------------------------------- control
   logic                 adv, issue, last_k, s_take, front_en;
   logic [XW-1:0]        n_cnt, n_m1;

   logic signed [MW-1:0] sq_pr [3];
   logic signed [MW-1:0] cr_pr [3];
   logic signed [MW-1:0] xyz_pr;
   logic signed [MW-1:0] lq_pr [6];
   logic signed [MW-1:0] cb_pr [3];
   logic signed [PW-1:0] ex [3];
   logic signed [FW-1:0] fsum [4];
   logic signed [GW-1:0] gsum [3];

   // The result stages move whenever the output register can take a beat; the front stages also wait for the sequencer.
   assign adv      = !rsp_vld_ff || rsp.ready;
   assign n_cnt    = lbe3d_pkg::basis_count(set_ff);
   assign n_m1     = n_cnt - XW'(1);
   assign last_k   = (k_ff == n_m1);
   assign issue    = s_vld_ff && adv;
   assign s_take   = !s_vld_ff || (issue && last_k);
   assign front_en = adv && s_take;
   assign req.ready = front_en;

   // Configuration writes.
   always_comb begin
      set_in = set_ff;
      for (int a = 0; a < 3; a++) scl_in[a] = scl_ff[a];
      if (csr_wr_en) begin
         unique case (lbe3d_pkg::csr_idx_type'(csr_index))
            lbe3d_pkg::CSR_BASIS_SET: set_in    = csr_wdata[1:0];
            lbe3d_pkg::CSR_X_SCALE:   scl_in[0] = csr_wdata;
            lbe3d_pkg::CSR_Y_SCALE:   scl_in[1] = csr_wdata;
            lbe3d_pkg::CSR_Z_SCALE:   scl_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff <= lbe3d_pkg::BASIS_SET_20;
         for (int a = 0; a < 3; a++) scl_ff[a] <= SCALE_RST;
      end else begin
         set_ff <= set_in;
         for (int a = 0; a < 3; a++) scl_ff[a] <= scl_in[a];
      end
   end

   // Stage A: capture the point beat.
   always_comb begin
      a_vld_in  = req.valid;
      a_last_in = req.final_point;
      a_c_in[0] = req.xi_coord;
      a_c_in[1] = req.eta_coord;
      a_c_in[2] = req.zeta_coord;
   end

   // Stage B: squares and cross products.
   always_comb begin
      sq_pr[0] = a_c_ff[0] * a_c_ff[0];
      sq_pr[1] = a_c_ff[1] * a_c_ff[1];
      sq_pr[2] = a_c_ff[2] * a_c_ff[2];
      cr_pr[0] = a_c_ff[0] * a_c_ff[1];
      cr_pr[1] = a_c_ff[0] * a_c_ff[2];
      cr_pr[2] = a_c_ff[1] * a_c_ff[2];
      b_vld_in  = a_vld_ff;
      b_last_in = a_last_ff;
      for (int a = 0; a < 3; a++) begin
         b_c_in[a]  = a_c_ff[a];
         b_sq_in[a] = PW'(rnd_pt(sq_pr[a]));
         b_cr_in[a] = PW'(rnd_pt(cr_pr[a]));
      end
   end

   // Stage C: xyz and the quadratic terms.
   always_comb begin
      xyz_pr    = b_cr_ff[0] * b_c_ff[2];
      c_xyz_in  = PW'(rnd_pt(xyz_pr));
      c_vld_in  = b_vld_ff;
      c_last_in = b_last_ff;
      for (int a = 0; a < 3; a++) begin
         c_c_in[a]  = b_c_ff[a];
         c_cr_in[a] = b_cr_ff[a];
         c_q_in[a]  = (b_sq_ff[a] <<< 1) + b_sq_ff[a] - ONE_FX;
         c_d5_in[a] = (b_sq_ff[a] <<< 2) + b_sq_ff[a] - ONE_FX;
         c_c5_in[a] = (b_sq_ff[a] <<< 2) + b_sq_ff[a] - THREE_FX;
      end
   end

   // Stage D (sequencer): linear-times-quadratic and cubic terms, then the index walk.
   always_comb begin
      lq_pr[0] = c_c_ff[1] * c_q_ff[0];
      lq_pr[1] = c_c_ff[2] * c_q_ff[0];
      lq_pr[2] = c_c_ff[0] * c_q_ff[1];
      lq_pr[3] = c_c_ff[2] * c_q_ff[1];
      lq_pr[4] = c_c_ff[0] * c_q_ff[2];
      lq_pr[5] = c_c_ff[1] * c_q_ff[2];
      for (int a = 0; a < 3; a++) cb_pr[a] = c_c_ff[a] * c_c5_ff[a];
      for (int i = 0; i < 6; i++) s_lq_in[i] = PW'(rnd_pt(lq_pr[i]));
      for (int a = 0; a < 3; a++) begin
         s_cb_in[a] = PW'(rnd_pt(cb_pr[a]));
         s_c_in[a]  = c_c_ff[a];
         s_cr_in[a] = c_cr_ff[a];
         s_q_in[a]  = c_q_ff[a];
         s_d5_in[a] = c_d5_ff[a];
      end
      s_xyz_in  = c_xyz_ff;
      s_last_in = c_last_ff;
      s_vld_in  = s_vld_ff;
      k_in      = k_ff;
      if (front_en) begin
         s_vld_in = c_vld_ff;
         k_in     = '0;
      end else if (issue) begin
         k_in = k_ff + XW'(1);
      end
   end

   // Stage R1: pick the polynomial and constant of each lane for this index.
   always_comb begin
      for (int a = 0; a < 3; a++) ex[a] = PW'(s_c_ff[a]);
      for (int l = 0; l < 4; l++) begin
         r1_p_in[l] = '0;
         r1_k_in[l] = '0;
      end
      unique case (k_ff)
         5'd0: begin
            r1_p_in[0] = ONE_FX;        r1_k_in[0] = lbe3d_pkg::K_ONE;
         end
         5'd1: begin
            r1_p_in[0] = ex[0];         r1_k_in[0] = lbe3d_pkg::K_R3;
            r1_p_in[1] = ONE_FX;        r1_k_in[1] = lbe3d_pkg::K_R3;
         end
         5'd2: begin
            r1_p_in[0] = ex[1];         r1_k_in[0] = lbe3d_pkg::K_R3;
            r1_p_in[2] = ONE_FX;        r1_k_in[2] = lbe3d_pkg::K_R3;
         end
         5'd3: begin
            r1_p_in[0] = ex[2];         r1_k_in[0] = lbe3d_pkg::K_R3;
            r1_p_in[3] = ONE_FX;        r1_k_in[3] = lbe3d_pkg::K_R3;
         end
         5'd4: begin
            r1_p_in[0] = s_cr_ff[0];    r1_k_in[0] = lbe3d_pkg::K_3;
            r1_p_in[1] = ex[1];         r1_k_in[1] = lbe3d_pkg::K_3;
            r1_p_in[2] = ex[0];         r1_k_in[2] = lbe3d_pkg::K_3;
         end
         5'd5: begin
            r1_p_in[0] = s_cr_ff[1];    r1_k_in[0] = lbe3d_pkg::K_3;
            r1_p_in[1] = ex[2];         r1_k_in[1] = lbe3d_pkg::K_3;
            r1_p_in[3] = ex[0];         r1_k_in[3] = lbe3d_pkg::K_3;
         end
         5'd6: begin
            r1_p_in[0] = s_cr_ff[2];    r1_k_in[0] = lbe3d_pkg::K_3;
            r1_p_in[2] = ex[2];         r1_k_in[2] = lbe3d_pkg::K_3;
            r1_p_in[3] = ex[1];         r1_k_in[3] = lbe3d_pkg::K_3;
         end
         5'd7: begin
            r1_p_in[0] = s_q_ff[0];     r1_k_in[0] = lbe3d_pkg::K_H5;
            r1_p_in[1] = ex[0];         r1_k_in[1] = lbe3d_pkg::K_3R5;
         end
         5'd8: begin
            r1_p_in[0] = s_q_ff[1];     r1_k_in[0] = lbe3d_pkg::K_H5;
            r1_p_in[2] = ex[1];         r1_k_in[2] = lbe3d_pkg::K_3R5;
         end
         5'd9: begin
            r1_p_in[0] = s_q_ff[2];     r1_k_in[0] = lbe3d_pkg::K_H5;
            r1_p_in[3] = ex[2];         r1_k_in[3] = lbe3d_pkg::K_3R5;
         end
         5'd10: begin
            r1_p_in[0] = s_lq_ff[0];    r1_k_in[0] = lbe3d_pkg::K_H15;
            r1_p_in[1] = s_cr_ff[0];    r1_k_in[1] = lbe3d_pkg::K_3R15;
            r1_p_in[2] = s_q_ff[0];     r1_k_in[2] = lbe3d_pkg::K_H15;
         end
         5'd11: begin
            r1_p_in[0] = s_lq_ff[1];    r1_k_in[0] = lbe3d_pkg::K_H15;
            r1_p_in[1] = s_cr_ff[1];    r1_k_in[1] = lbe3d_pkg::K_3R15;
            r1_p_in[3] = s_q_ff[0];     r1_k_in[3] = lbe3d_pkg::K_H15;
         end
         5'd12: begin
            r1_p_in[0] = s_lq_ff[2];    r1_k_in[0] = lbe3d_pkg::K_H15;
            r1_p_in[1] = s_q_ff[1];     r1_k_in[1] = lbe3d_pkg::K_H15;
            r1_p_in[2] = s_cr_ff[0];    r1_k_in[2] = lbe3d_pkg::K_3R15;
         end
         5'd13: begin
            r1_p_in[0] = s_lq_ff[3];    r1_k_in[0] = lbe3d_pkg::K_H15;
            r1_p_in[2] = s_cr_ff[2];    r1_k_in[2] = lbe3d_pkg::K_3R15;
            r1_p_in[3] = s_q_ff[1];     r1_k_in[3] = lbe3d_pkg::K_H15;
         end
         5'd14: begin
            r1_p_in[0] = s_lq_ff[4];    r1_k_in[0] = lbe3d_pkg::K_H15;
            r1_p_in[1] = s_q_ff[2];     r1_k_in[1] = lbe3d_pkg::K_H15;
            r1_p_in[3] = s_cr_ff[1];    r1_k_in[3] = lbe3d_pkg::K_3R15;
         end
         5'd15: begin
            r1_p_in[0] = s_lq_ff[5];    r1_k_in[0] = lbe3d_pkg::K_H15;
            r1_p_in[2] = s_q_ff[2];     r1_k_in[2] = lbe3d_pkg::K_H15;
            r1_p_in[3] = s_cr_ff[2];    r1_k_in[3] = lbe3d_pkg::K_3R15;
         end
         5'd16: begin
            r1_p_in[0] = s_xyz_ff;      r1_k_in[0] = lbe3d_pkg::K_3R3;
            r1_p_in[1] = s_cr_ff[2];    r1_k_in[1] = lbe3d_pkg::K_3R3;
            r1_p_in[2] = s_cr_ff[1];    r1_k_in[2] = lbe3d_pkg::K_3R3;
            r1_p_in[3] = s_cr_ff[0];    r1_k_in[3] = lbe3d_pkg::K_3R3;
         end
         5'd17: begin
            r1_p_in[0] = s_cb_ff[0];    r1_k_in[0] = lbe3d_pkg::K_H7;
            r1_p_in[1] = s_d5_ff[0];    r1_k_in[1] = lbe3d_pkg::K_D7;
         end
         5'd18: begin
            r1_p_in[0] = s_cb_ff[1];    r1_k_in[0] = lbe3d_pkg::K_H7;
            r1_p_in[2] = s_d5_ff[1];    r1_k_in[2] = lbe3d_pkg::K_D7;
         end
         5'd19: begin
            r1_p_in[0] = s_cb_ff[2];    r1_k_in[0] = lbe3d_pkg::K_H7;
            r1_p_in[3] = s_d5_ff[2];    r1_k_in[3] = lbe3d_pkg::K_D7;
         end
         default: ;
      endcase
      r1_vld_in = s_vld_ff;
      r1_idx_in = k_ff + XW'(1);
      r1_lb_in  = last_k;
      r1_ls_in  = last_k && s_last_ff;
   end

   // Stage R2: polynomial times the two halves of the constant.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         r2_pl_in[l] = r1_p_ff[l] * $signed({1'b0, r1_k_ff[l][KH-1:0]});
         r2_ph_in[l] = r1_p_ff[l] * $signed({1'b0, r1_k_ff[l][KW-1:KH]});
      end
      r2_vld_in = r1_vld_ff;
      r2_idx_in = r1_idx_ff;
      r2_lb_in  = r1_lb_ff;
      r2_ls_in  = r1_ls_ff;
   end

   // Stage R3: join the halves and drop the constant's fraction bits.
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         fsum[l]    = (FW'(r2_ph_ff[l]) <<< KH) + FW'(r2_pl_ff[l]);
         r3_d_in[l] = DW'(rnd_k(fsum[l]));
      end
      r3_vld_in = r2_vld_ff;
      r3_idx_in = r2_idx_ff;
      r3_lb_in  = r2_lb_ff;
      r3_ls_in  = r2_ls_ff;
   end

   // Stage R4: derivative terms times the two halves of their axis scale.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         r4_gl_in[a] = r3_d_ff[a + 1] * $signed({1'b0, scl_ff[a][SH-1:0]});
         r4_gh_in[a] = r3_d_ff[a + 1] * $signed({1'b0, scl_ff[a][SW-1:SH]});
      end
      r4_v_in   = r3_d_ff[0];
      r4_vld_in = r3_vld_ff;
      r4_idx_in = r3_idx_ff;
      r4_lb_in  = r3_lb_ff;
      r4_ls_in  = r3_ls_ff;
   end

   // Stage R5: round the scaled gradients and saturate everything to 32 bits.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         gsum[a]     = (GW'(r4_gh_ff[a]) <<< SH) + GW'(r4_gl_ff[a]);
         rsp_g_in[a] = sat_g(rnd_g(gsum[a]));
      end
      rsp_val_in = sat_d(r4_v_ff);
      rsp_vld_in = r4_vld_ff;
      rsp_idx_in = r4_idx_ff;
      rsp_lb_in  = r4_lb_ff;
      rsp_ls_in  = r4_ls_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         s_vld_ff   <= 1'b0;
         k_ff       <= '0;
         r1_vld_ff  <= 1'b0;
         r2_vld_ff  <= 1'b0;
         r3_vld_ff  <= 1'b0;
         r4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (front_en) begin
            a_vld_ff <= a_vld_in;
            b_vld_ff <= b_vld_in;
            c_vld_ff <= c_vld_in;
         end
         s_vld_ff <= s_vld_in;
         k_ff     <= k_in;
         if (adv) begin
            r1_vld_ff  <= r1_vld_in;
            r2_vld_ff  <= r2_vld_in;
            r3_vld_ff  <= r3_vld_in;
            r4_vld_ff  <= r4_vld_in;
            rsp_vld_ff <= rsp_vld_in;
         end
      end
   end

   // Point payload.
   always_ff @(posedge clock) begin
      if (front_en) begin
         a_last_ff <= a_last_in;
         b_last_ff <= b_last_in;
         c_last_ff <= c_last_in;
         c_xyz_ff  <= c_xyz_in;
         s_last_ff <= s_last_in;
         s_xyz_ff  <= s_xyz_in;
         for (int a = 0; a < 3; a++) begin
            a_c_ff[a]  <= a_c_in[a];
            b_c_ff[a]  <= b_c_in[a];
            b_sq_ff[a] <= b_sq_in[a];
            b_cr_ff[a] <= b_cr_in[a];
            c_c_ff[a]  <= c_c_in[a];
            c_cr_ff[a] <= c_cr_in[a];
            c_q_ff[a]  <= c_q_in[a];
            c_d5_ff[a] <= c_d5_in[a];
            c_c5_ff[a] <= c_c5_in[a];
            s_c_ff[a]  <= s_c_in[a];
            s_cr_ff[a] <= s_cr_in[a];
            s_q_ff[a]  <= s_q_in[a];
            s_d5_ff[a] <= s_d5_in[a];
            s_cb_ff[a] <= s_cb_in[a];
         end
         for (int i = 0; i < 6; i++) s_lq_ff[i] <= s_lq_in[i];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         r1_idx_ff  <= r1_idx_in;
         r1_lb_ff   <= r1_lb_in;
         r1_ls_ff   <= r1_ls_in;
         r2_idx_ff  <= r2_idx_in;
         r2_lb_ff   <= r2_lb_in;
         r2_ls_ff   <= r2_ls_in;
         r3_idx_ff  <= r3_idx_in;
         r3_lb_ff   <= r3_lb_in;
         r3_ls_ff   <= r3_ls_in;
         r4_idx_ff  <= r4_idx_in;
         r4_lb_ff   <= r4_lb_in;
         r4_ls_ff   <= r4_ls_in;
         r4_v_ff    <= r4_v_in;
         rsp_idx_ff <= rsp_idx_in;
         rsp_lb_ff  <= rsp_lb_in;
         rsp_ls_ff  <= rsp_ls_in;
         rsp_val_ff <= rsp_val_in;
         for (int l = 0; l < 4; l++) begin
            r1_p_ff[l]  <= r1_p_in[l];
            r1_k_ff[l]  <= r1_k_in[l];
            r2_pl_ff[l] <= r2_pl_in[l];
            r2_ph_ff[l] <= r2_ph_in[l];
            r3_d_ff[l]  <= r3_d_in[l];
         end
         for (int a = 0; a < 3; a++) begin
            r4_gl_ff[a] <= r4_gl_in[a];
            r4_gh_ff[a] <= r4_gh_in[a];
            rsp_g_ff[a] <= rsp_g_in[a];
         end
      end
   end

   // Result beat.
   assign rsp.valid       = rsp_vld_ff;
   assign rsp.basis_index = rsp_idx_ff;
   assign rsp.basis_value = rsp_val_ff;
   assign rsp.grad_x      = rsp_g_ff[0];
   assign rsp.grad_y      = rsp_g_ff[1];
   assign rsp.grad_z      = rsp_g_ff[2];
   assign rsp.last_basis  = rsp_lb_ff;
   assign rsp.last_of_set = rsp_ls_ff;

   // The basis index walk stays inside the configured set.
   `ASSERT_IMPLY(a_k_range, clock, reset, s_vld_ff, k_ff <= n_m1)
   // The closing beat of a point carries the highest index of the set.
   `ASSERT_IMPLY(a_last_idx, clock, reset, rsp_vld_ff && rsp_lb_ff, rsp_idx_ff == n_cnt)
   // The set marker only rides on the closing beat of a point.
   `ASSERT_IMPLY(a_set_on_last, clock, reset, rsp_vld_ff && rsp_ls_ff, rsp_lb_ff)
   // A point handed to the sequencer starts at the first basis function.
   `ASSERT_NEXT(a_seq_start, clock, reset, front_en && c_vld_ff, s_vld_ff && k_ff == '0)

endmodule
